// ----- rtl/qrv_pkg.sv -----
// ---------------------------------------------------------------------------
// qrv_pkg
// Shared constants and width helpers for the quaternion vector rotator.
// ---------------------------------------------------------------------------
package qrv_pkg;

  localparam int QRV_DATA_WIDTH = 16;
  localparam int QRV_FRAC_BITS  = 14;

  // component slots of a quaternion or vector array
  localparam int QX = 0;
  localparam int QY = 1;
  localparam int QZ = 2;
  localparam int QW = 3;

  // exact width of a three-term sum of input products, with room for the half lsb
  function automatic int qrv_fwd_sum_w(input int dw, input int fb);
    return (2 * dw + 2 > fb + 1) ? 2 * dw + 2 : fb + 2;
  endfunction

  // width of the intermediate product q * v after rounding
  function automatic int qrv_t_w(input int dw, input int fb);
    return qrv_fwd_sum_w(dw, fb) - fb;
  endfunction

  // exact width of a four-term sum of t * q products
  function automatic int qrv_bwd_sum_w(input int dw, input int fb);
    int tw;
    tw = qrv_t_w(dw, fb);
    return (tw + dw + 2 > fb + 1) ? tw + dw + 2 : fb + 2;
  endfunction

endpackage

// ----- rtl/qrv_fwd.sv -----
// ---------------------------------------------------------------------------
// qrv_fwd
// Two pipeline stages forming t = q * (v, 0): products, then exact sums rounded.
// ---------------------------------------------------------------------------
module qrv_fwd import qrv_pkg::*; #(
  parameter int DATA_WIDTH = QRV_DATA_WIDTH,
  parameter int FRAC_BITS  = QRV_FRAC_BITS,
  localparam int TW        = qrv_t_w(DATA_WIDTH, FRAC_BITS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [DATA_WIDTH-1:0] q_i [4],
  input  logic signed [DATA_WIDTH-1:0] v_i [3],
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [DATA_WIDTH-1:0] q_o [4],
  output logic signed [TW-1:0]         t_o [4]
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam int SW = qrv_fwd_sum_w(DATA_WIDTH, FRAC_BITS);
  localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

  logic                         v1_r, v2_r;
  logic                         rdy1, rdy2;
  logic signed [PW-1:0]         p_r   [12];
  logic signed [PW-1:0]         p_nxt [12];
  logic signed [DATA_WIDTH-1:0] q1_r  [4];
  logic signed [DATA_WIDTH-1:0] q2_r  [4];
  logic signed [SW-1:0]         s     [4];
  logic signed [SW-1:0]         rs    [4];
  logic signed [TW-1:0]         t_nxt [4];
  logic signed [TW-1:0]         t_r   [4];

  assign rdy2     = !v2_r || dn_ready;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v2_r;
  assign q_o      = q2_r;
  assign t_o      = t_r;

  // product order: w-term group, then x, y, z groups of three
  always_comb begin
    p_nxt[0]  = q_i[QX] * v_i[QX];
    p_nxt[1]  = q_i[QY] * v_i[QY];
    p_nxt[2]  = q_i[QZ] * v_i[QZ];
    p_nxt[3]  = q_i[QW] * v_i[QX];
    p_nxt[4]  = q_i[QY] * v_i[QZ];
    p_nxt[5]  = q_i[QZ] * v_i[QY];
    p_nxt[6]  = q_i[QW] * v_i[QY];
    p_nxt[7]  = q_i[QZ] * v_i[QX];
    p_nxt[8]  = q_i[QX] * v_i[QZ];
    p_nxt[9]  = q_i[QW] * v_i[QZ];
    p_nxt[10] = q_i[QX] * v_i[QY];
    p_nxt[11] = q_i[QY] * v_i[QX];
  end

  always_comb begin
    s[QW] = -SW'(p_r[0]) - SW'(p_r[1]) - SW'(p_r[2]);
    for (int k = 0; k < 3; k++) begin
      s[k] = SW'(p_r[3*k+3]) + SW'(p_r[3*k+4]) - SW'(p_r[3*k+5]);
    end
    for (int k = 0; k < 4; k++) begin
      rs[k]    = (s[k] + HALF) >>> FRAC_BITS;
      t_nxt[k] = rs[k][TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      p_r  <= p_nxt;
      q1_r <= q_i;
    end
    if (rdy2 && v1_r) begin
      t_r  <= t_nxt;
      q2_r <= q1_r;
    end
  end

endmodule

// ----- rtl/qrv_bwd.sv -----
// ---------------------------------------------------------------------------
// qrv_bwd
// Two pipeline stages forming the vector part of t * conj(q), rounded and
// saturated into the output register.
// ---------------------------------------------------------------------------
module qrv_bwd import qrv_pkg::*; #(
  parameter int DATA_WIDTH = QRV_DATA_WIDTH,
  parameter int FRAC_BITS  = QRV_FRAC_BITS,
  localparam int TW        = qrv_t_w(DATA_WIDTH, FRAC_BITS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [DATA_WIDTH-1:0] q_i [4],
  input  logic signed [TW-1:0]         t_i [4],
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [DATA_WIDTH-1:0] r_o [3]
);

  localparam int PW = TW + DATA_WIDTH;
  localparam int SW = qrv_bwd_sum_w(DATA_WIDTH, FRAC_BITS);
  localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] MAXV = (SW'(1) << (DATA_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MINV = -(SW'(1) << (DATA_WIDTH - 1));

  logic                         v3_r, v4_r;
  logic                         rdy3, rdy4;
  logic signed [PW-1:0]         p_r   [12];
  logic signed [PW-1:0]         p_nxt [12];
  logic signed [SW-1:0]         s     [3];
  logic signed [SW-1:0]         rs    [3];
  logic signed [DATA_WIDTH-1:0] r_nxt [3];
  logic signed [DATA_WIDTH-1:0] r_r   [3];

  assign rdy4     = !v4_r || dn_ready;
  assign rdy3     = !v3_r || rdy4;
  assign up_ready = rdy3;
  assign dn_valid = v4_r;
  assign r_o      = r_r;

  // per axis a with cyclic b, c: +t[a]q[w] - t[b]q[c] + t[c]q[b] - t[w]q[a]
  for (genvar k = 0; k < 3; k++) begin : g_axis
    localparam int B = (k + 1) % 3;
    localparam int C = (k + 2) % 3;

    always_comb begin
      p_nxt[4*k]   = t_i[k]  * q_i[QW];
      p_nxt[4*k+1] = t_i[B]  * q_i[C];
      p_nxt[4*k+2] = t_i[C]  * q_i[B];
      p_nxt[4*k+3] = t_i[QW] * q_i[k];
    end

    always_comb begin
      s[k]  = SW'(p_r[4*k]) - SW'(p_r[4*k+1]) + SW'(p_r[4*k+2]) - SW'(p_r[4*k+3]);
      rs[k] = (s[k] + HALF) >>> FRAC_BITS;
      if (rs[k] > MAXV) begin
        r_nxt[k] = MAXV[DATA_WIDTH-1:0];
      end else if (rs[k] < MINV) begin
        r_nxt[k] = MINV[DATA_WIDTH-1:0];
      end else begin
        r_nxt[k] = rs[k][DATA_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy3) v3_r <= up_valid;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && up_valid) p_r <= p_nxt;
    if (rdy4 && v3_r)     r_r <= r_nxt;
  end

endmodule

// ----- rtl/quaternion_rotate_vector.sv -----
// ---------------------------------------------------------------------------
// quaternion_rotate_vector
// Rotates a vector by a quaternion, q * v * conj(q), in signed fixed point.
//
//   channel  ports                               direction  word
//   in       in_valid, in_stall, in_quat_*,      in         quaternion + vector
//            in_vec_*
//   out      out_valid, out_stall, out_rot_*     out        rotated vector
//
// One word per cycle sustained while out_stall is low; an accepted word passes
// through the product, sum/round, product and sum/round/saturate stages in turn.
// Reset clears only the stage valid bits; the pipeline is empty after reset.
// Each stage advances when it is empty or the next one moves, so bubbles
// collapse under out_stall and a held result stalls the input only once
// every stage holds a word.
// ---------------------------------------------------------------------------
module quaternion_rotate_vector import qrv_pkg::*; #(
  parameter int DATA_WIDTH = QRV_DATA_WIDTH,
  parameter int FRAC_BITS  = QRV_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_quat_x,
  input  logic signed [DATA_WIDTH-1:0] in_quat_y,
  input  logic signed [DATA_WIDTH-1:0] in_quat_z,
  input  logic signed [DATA_WIDTH-1:0] in_quat_w,
  input  logic signed [DATA_WIDTH-1:0] in_vec_x,
  input  logic signed [DATA_WIDTH-1:0] in_vec_y,
  input  logic signed [DATA_WIDTH-1:0] in_vec_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_rot_x,
  output logic signed [DATA_WIDTH-1:0] out_rot_y,
  output logic signed [DATA_WIDTH-1:0] out_rot_z
);

  localparam int TW = qrv_t_w(DATA_WIDTH, FRAC_BITS);

  logic                         fwd_ready;
  logic                         mid_valid;
  logic                         mid_ready;
  logic signed [DATA_WIDTH-1:0] q_in  [4];
  logic signed [DATA_WIDTH-1:0] v_in  [3];
  logic signed [DATA_WIDTH-1:0] q_mid [4];
  logic signed [TW-1:0]         t_mid [4];
  logic signed [DATA_WIDTH-1:0] rot   [3];

  assign q_in[QX] = in_quat_x;
  assign q_in[QY] = in_quat_y;
  assign q_in[QZ] = in_quat_z;
  assign q_in[QW] = in_quat_w;
  assign v_in[QX] = in_vec_x;
  assign v_in[QY] = in_vec_y;
  assign v_in[QZ] = in_vec_z;

  assign in_stall = !fwd_ready;

  qrv_fwd #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_fwd (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (fwd_ready),
    .q_i      (q_in),
    .v_i      (v_in),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .q_o      (q_mid),
    .t_o      (t_mid)
  );

  qrv_bwd #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_bwd (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .q_i      (q_mid),
    .t_i      (t_mid),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .r_o      (rot)
  );

  assign out_rot_x = rot[QX];
  assign out_rot_y = rot[QY];
  assign out_rot_z = rot[QZ];

endmodule

// ----- tb/quaternion_rotate_vector_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// quaternion_rotate_vector_test
// Checks the quaternion vector rotator against a behavioral predictor of
// q * v * conj(q) in signed fixed point. The run opens with directed corner
// words, then sends random words. The source idles and the receiver stalls at random.
// Every accepted result is compared with the oldest pending rotation.
// ---------------------------------------------------------------------------
module quaternion_rotate_vector_test;
  import qrv_pkg::*;

  localparam int DW = QRV_DATA_WIDTH;
  localparam int FB = QRV_FRAC_BITS;

  localparam longint ONE  = longint'(1) <<< FB;
  localparam longint MAXV = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint MINV = -(longint'(1) <<< (DW - 1));
  localparam longint COS45 = 11585;  // cos(pi/4) in q2.14

  localparam int N_RANDOM       = 750;
  localparam int HOLD_AT        = 200;
  localparam int HOLD_CYCLES    = 80;
  localparam int PAUSE_AT       = 400;
  localparam int BURST_FROM     = 500;
  localparam int BURST_TO       = 620;
  localparam int IDLE_PCT       = 24;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic signed [DW-1:0] comp_t;

  typedef struct {
    comp_t qx, qy, qz, qw;
    comp_t vx, vy, vz;
  } rot_word_t;

  typedef struct {
    comp_t rx, ry, rz;
  } rot_result_t;

  typedef enum {MIX_FULL, MIX_UNIT, MIX_TINY, MIX_CORNER} mix_t;

  logic  clk;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  comp_t in_quat_x = '0;
  comp_t in_quat_y = '0;
  comp_t in_quat_z = '0;
  comp_t in_quat_w = '0;
  comp_t in_vec_x  = '0;
  comp_t in_vec_y  = '0;
  comp_t in_vec_z  = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  comp_t out_rot_x;
  comp_t out_rot_y;
  comp_t out_rot_z;

  rot_word_t   pending_words[$];
  rot_result_t rotations_due[$];

  logic        in_fire    = 1'b0;
  int          n_accepted = 0;
  int          idle_cycles = 0;
  int          err_cnt    = 0;
  int          hold_left  = 0;
  bit          hold_done  = 1'b0;
  bit          pause_done = 1'b0;
  bit          burst;
  rot_word_t   next_word;
  rot_word_t   taken_word;
  rot_result_t due;

  quaternion_rotate_vector #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_quat_x(in_quat_x),
    .in_quat_y(in_quat_y),
    .in_quat_z(in_quat_z),
    .in_quat_w(in_quat_w),
    .in_vec_x (in_vec_x),
    .in_vec_y (in_vec_y),
    .in_vec_z (in_vec_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rot_x(out_rot_x),
    .out_rot_y(out_rot_y),
    .out_rot_z(out_rot_z)
  );

  // round half up, then drop the fraction bits
  function automatic longint round_frac(longint a);
    return (a + (longint'(1) <<< (FB - 1))) >>> FB;
  endfunction

  function automatic comp_t clamp_comp(longint a);
    if (a > MAXV) return comp_t'(MAXV);
    if (a < MINV) return comp_t'(MINV);
    return comp_t'(a);
  endfunction

  function automatic rot_result_t rotate_vector(rot_word_t w);
    longint qx, qy, qz, qw, vx, vy, vz;
    longint tx, ty, tz, tw;
    rot_result_t r;
    qx = w.qx; qy = w.qy; qz = w.qz; qw = w.qw;
    vx = w.vx; vy = w.vy; vz = w.vz;
    // t = q * (v, 0), rounded but kept wide
    tw = round_frac(-qx * vx - qy * vy - qz * vz);
    tx = round_frac(qw * vx + qy * vz - qz * vy);
    ty = round_frac(qw * vy + qz * vx - qx * vz);
    tz = round_frac(qw * vz + qx * vy - qy * vx);
    // vector part of t * conj(q)
    r.rx = clamp_comp(round_frac(tx * qw - ty * qz + tz * qy - tw * qx));
    r.ry = clamp_comp(round_frac(ty * qw - tz * qx + tx * qz - tw * qy));
    r.rz = clamp_comp(round_frac(tz * qw - tx * qy + ty * qx - tw * qz));
    return r;
  endfunction

  function automatic comp_t pick_comp(mix_t kind);
    int v;
    v = 0;
    case (kind)
      MIX_FULL: v = $urandom;
      MIX_UNIT: v = int'($urandom_range(0, 2 * COS45)) - int'(COS45);
      MIX_TINY: v = int'($urandom_range(0, 128)) - 64;
      MIX_CORNER: begin
        case ($urandom_range(0, 5))
          0: v = int'(MINV);
          1: v = int'(MAXV);
          2: v = 0;
          3: v = int'(ONE);
          4: v = -int'(ONE);
          default: v = $urandom;
        endcase
      end
      default: v = $urandom;
    endcase
    return comp_t'(v);
  endfunction

  task automatic add_word(longint qx, longint qy, longint qz, longint qw,
                          longint vx, longint vy, longint vz);
    rot_word_t w;
    w.qx = comp_t'(qx); w.qy = comp_t'(qy); w.qz = comp_t'(qz); w.qw = comp_t'(qw);
    w.vx = comp_t'(vx); w.vy = comp_t'(vy); w.vz = comp_t'(vz);
    pending_words.push_back(w);
  endtask

  task automatic check_comp(string name, comp_t exp_v, comp_t act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rotations_due.size() == 0) begin
          $error("result word with no rotation pending: %0d %0d %0d",
                 out_rot_x, out_rot_y, out_rot_z);
          err_cnt++;
        end else begin
          due = rotations_due.pop_front();
          check_comp("rot_x", due.rx, out_rot_x);
          check_comp("rot_y", due.ry, out_rot_y);
          check_comp("rot_z", due.rz, out_rot_z);
        end
      end
      if (in_valid && !in_stall) begin
        taken_word.qx = in_quat_x; taken_word.qy = in_quat_y;
        taken_word.qz = in_quat_z; taken_word.qw = in_quat_w;
        taken_word.vx = in_vec_x;  taken_word.vy = in_vec_y;
        taken_word.vz = in_vec_z;
        rotations_due.push_back(rotate_vector(taken_word));
        n_accepted++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      in_fire <= in_valid && !in_stall;
    end
  end

  // driver: present a new word once the previous one was taken
  always @(negedge clk) begin
    burst = (n_accepted >= BURST_FROM) && (n_accepted < BURST_TO);
    if (n_accepted == PAUSE_AT && !pause_done && rotations_due.size() == 0)
      pause_done = 1'b1;
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_words.size() != 0 && !(n_accepted == PAUSE_AT && !pause_done) &&
          (burst || $urandom_range(0, 99) >= IDLE_PCT)) begin
        next_word = pending_words.pop_front();
        in_quat_x <= next_word.qx;
        in_quat_y <= next_word.qy;
        in_quat_z <= next_word.qz;
        in_quat_w <= next_word.qw;
        in_vec_x  <= next_word.vx;
        in_vec_y  <= next_word.vy;
        in_vec_z  <= next_word.vz;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off so the pipeline backs up
  always @(negedge clk) begin
    if (rst_n && n_accepted >= HOLD_AT && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (n_accepted >= BURST_FROM && n_accepted < BURST_TO) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin
    // zero and identity
    add_word(0, 0, 0, 0, 0, 0, 0);
    add_word(0, 0, 0, ONE, ONE, -ONE, MAXV);
    add_word(0, 0, 0, ONE, MINV, MINV, MINV);
    add_word(0, 0, 0, -ONE, ONE, MAXV, MINV);
    // quarter and half turns
    add_word(0, 0, COS45, COS45, ONE, 0, 0);
    add_word(COS45, 0, 0, COS45, 0, ONE, 0);
    add_word(0, ONE, 0, 0, ONE, ONE, ONE);
    // full-scale fields, saturation both ways
    add_word(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    add_word(MINV, MINV, MINV, MINV, MINV, MINV, MINV);
    add_word(MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV);
    add_word(MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV);
    add_word(MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV);
    // most negative component in the conjugate terms
    add_word(MINV, 0, 0, 0, MINV, MINV, MINV);
    add_word(0, MINV, 0, MINV, 0, MINV, 0);
    // non-unit quaternions, scaled results
    add_word(0, 0, 0, MAXV, ONE, ONE / 2, -ONE);
    add_word(ONE, ONE, ONE, ONE, ONE, 0, 0);
    add_word(1, 1, 1, 1, 1, 1, 1);
    add_word(-1, -1, -1, -1, -1, -1, -1);
    // rounding ties at both stages
    add_word(0, 0, 0, ONE / 2, 1, -1, 3);
    add_word(0, 0, 0, ONE / 2, -1, 1, -3);
    add_word(1, 0, 0, 0, MAXV, MAXV, MAXV);
    add_word(0, 0, 0, MAXV, MAXV, MINV, 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      mix_t qk, vk;
      rot_word_t w;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: qk = MIX_FULL;
        8, 9, 10, 11, 12, 13:   qk = MIX_UNIT;
        14, 15, 16:             qk = MIX_TINY;
        default:                qk = MIX_CORNER;
      endcase
      vk = (qk == MIX_UNIT) ? MIX_FULL : qk;
      w.qx = pick_comp(qk); w.qy = pick_comp(qk);
      w.qz = pick_comp(qk); w.qw = pick_comp(qk);
      w.vx = pick_comp(vk); w.vy = pick_comp(vk); w.vz = pick_comp(vk);
      pending_words.push_back(w);
    end

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid || rotations_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_cnt == 0 && rotations_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog on cycles with no word moving on either channel
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/qrv_pkg.sv
rtl/qrv_fwd.sv
rtl/qrv_bwd.sv
rtl/quaternion_rotate_vector.sv
tb/quaternion_rotate_vector_test.sv
